@@ src/pnf_pkg.sv @@
// Shared types, character codes and the digit-to-ASCII helper of the printf
// number formatter. No dependencies.
`default_nettype none

package pnf_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int DEC_DIGITS  = 10;
    localparam int HEX_DIGITS  = 4;

    localparam logic [7:0] CHAR_NUL      = 8'h00;
    localparam logic [7:0] CHAR_PERCENT  = 8'h25;
    localparam logic [7:0] CHAR_MINUS    = 8'h2d;
    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] CHAR_HEX_BASE = 8'h37; // 'A' - 10
    localparam logic [7:0] CHAR_CONV_C   = 8'h63;
    localparam logic [7:0] CHAR_CONV_I   = 8'h69;
    localparam logic [7:0] CHAR_CONV_L   = 8'h6c;
    localparam logic [7:0] CHAR_CONV_N   = 8'h6e;
    localparam logic [7:0] CHAR_CONV_U   = 8'h75;
    localparam logic [7:0] CHAR_CONV_X   = 8'h78;

    typedef enum logic [1:0] {
        OP_CHAR = 2'd0,
        OP_DEC  = 2'd1,
        OP_HEX  = 2'd2
    } op_t;

    // one classified item, front to back
    typedef struct packed {
        op_t         op;
        logic        neg;    // decimal: send a minus sign first
        logic        wide;   // decimal: 32-bit magnitude, else 16-bit
        logic [31:0] value;  // char in [7:0], magnitude, or hex word in [15:0]
    } cmd_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        if (d < 4'd10)
            return CHAR_ZERO + {4'b0000, d};
        else
            return CHAR_HEX_BASE + {4'b0000, d};
    endfunction

endpackage

`default_nettype wire

@@ src/printf_number_formatter_core.sv @@
// Top level of the printf number formatter: front end, command queue and
// back end. Depends on pnf_pkg, pnf_front, pnf_queue and pnf_back.
//
// Input channel (in_valid / in_stall): one format character with its
// argument word per transaction. Output channel (out_valid / out_stall): one
// ASCII character per transaction; last_char marks the final character that
// an input item causes. An opening percent and NUL items produce nothing.
// Throughput: plain characters, %c and literal conversions go out at one per
// cycle while the output is not stalled. %x pops, then sends four digits.
// Decimal conversions pop, run shift-and-add-3 over 16 (%i, %u) or 32 (%l, %n)
// bits, then step through 10 digits (leading zeros skipped one per cycle
// unless the output stalls) after any minus sign; the back end runs one
// command at a time. A plain character passes through the queue and the
// output register. The queue lets the front end keep accepting while the
// back end converts; in_stall rises only when the queue is full.
// A stalled output holds its character; the back end waits for the slot.
// Reset clears the pending percent, empties the queue and drops any output.
`default_nettype none

module printf_number_formatter_core #(
    parameter int QUEUE_DEPTH = pnf_pkg::QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [7:0]    format_char,
    input  wire logic [31:0]   arg_word,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [7:0]         out_char,
    output logic               last_char
);
    import pnf_pkg::*;

    cmd_t push_cmd;
    cmd_t pop_cmd;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_valid;

    pnf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .format_char (format_char),
        .arg_word    (arg_word),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (push_cmd)
    );

    pnf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_cmd   (pop_cmd),
        .not_empty (q_valid)
    );

    pnf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (pop_cmd),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .last_char (last_char)
    );

`ifndef SYNTH
    // front end never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("command pushed into full queue");

    // back end only takes commands that exist
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("command popped from empty queue");

    // a pushed command leaves the queue non-empty next cycle
    a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |=> q_valid)
        else $error("pushed command lost");
`endif

endmodule

`default_nettype wire

@@ src/pnf_front.sv @@
// Front end: accepts format characters, tracks the pending percent and turns
// each item into a command for the back end. Depends on pnf_pkg.
`default_nettype none

module pnf_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [7:0]    format_char,
    input  wire logic [31:0]   arg_word,
    input  wire logic          q_full,
    output logic               q_push,
    output pnf_pkg::cmd_t      q_cmd
);
    import pnf_pkg::*;

    logic        pending_reg, pending_next;
    logic        accept;
    logic [15:0] neg16;
    logic [31:0] neg32;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign neg16    = 16'h0000 - arg_word[15:0];
    assign neg32    = 32'h0000_0000 - arg_word;

    always_comb
    begin
        pending_next = pending_reg;
        q_push       = 1'b0;
        q_cmd.op     = OP_CHAR;
        q_cmd.neg    = 1'b0;
        q_cmd.wide   = 1'b0;
        q_cmd.value  = {24'h000000, format_char};
        if (accept)
        begin
            if (!pending_reg)
            begin
                if (format_char == CHAR_PERCENT)
                    pending_next = 1'b1;
                else if (format_char != CHAR_NUL)
                    q_push = 1'b1;
            end
            else
            begin
                pending_next = 1'b0;
                q_push       = (format_char != CHAR_NUL);
                case (format_char)
                    CHAR_CONV_C:
                        q_cmd.value = {24'h000000, arg_word[7:0]};
                    CHAR_CONV_I:
                    begin
                        q_cmd.op    = OP_DEC;
                        q_cmd.neg   = arg_word[15];
                        // -32768 negates to itself, which is the right magnitude
                        q_cmd.value = {16'h0000, arg_word[15] ? neg16 : arg_word[15:0]};
                    end
                    CHAR_CONV_U:
                    begin
                        q_cmd.op    = OP_DEC;
                        q_cmd.value = {16'h0000, arg_word[15:0]};
                    end
                    CHAR_CONV_L:
                    begin
                        q_cmd.op    = OP_DEC;
                        q_cmd.wide  = 1'b1;
                        q_cmd.neg   = arg_word[31];
                        q_cmd.value = arg_word[31] ? neg32 : arg_word;
                    end
                    CHAR_CONV_N:
                    begin
                        q_cmd.op    = OP_DEC;
                        q_cmd.wide  = 1'b1;
                        q_cmd.value = arg_word;
                    end
                    CHAR_CONV_X:
                    begin
                        q_cmd.op    = OP_HEX;
                        q_cmd.value = {16'h0000, arg_word[15:0]};
                    end
                    default:
                        q_cmd.value = {24'h000000, format_char};
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= 1'b0;
        else
            pending_reg <= pending_next;
    end

endmodule

`default_nettype wire

@@ src/pnf_queue.sv @@
// Small register FIFO of commands between front and back end.
// Depends on pnf_pkg.
`default_nettype none

module pnf_queue #(
    parameter int DEPTH = pnf_pkg::QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire pnf_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output pnf_pkg::cmd_t      pop_cmd,
    output logic               not_empty
);
    import pnf_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t            entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

@@ src/pnf_back.sv @@
// Back end: executes commands, converting binary to BCD by shift-and-add-3
// and sending characters through an output register. Depends on pnf_pkg.
`default_nettype none

module pnf_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    input  wire pnf_pkg::cmd_t q_cmd,
    output logic               q_pop,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [7:0]         out_char,
    output logic               last_char
);
    import pnf_pkg::*;

    localparam int BCD_W = 4 * DEC_DIGITS;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [31:0]      bin_reg, bin_next;
    logic [BCD_W-1:0] bcd_reg, bcd_next;
    logic [5:0]       bits_reg, bits_next;
    logic [3:0]       left_reg, left_next;
    logic             neg_reg, neg_next;
    logic             started_reg, started_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_char_reg, out_char_next;
    logic             last_reg, last_next;

    logic             out_free;
    logic [BCD_W-1:0] bcd_adj;
    logic [3:0]       top_digit;

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last_char = last_reg;
    assign top_digit = bcd_reg[BCD_W-1 -: 4];

    always_comb
    begin
        for (int k = 0; k < DEC_DIGITS; k++)
        begin
            if (bcd_reg[4*k +: 4] >= 4'd5)
                bcd_adj[4*k +: 4] = bcd_reg[4*k +: 4] + 4'd3;
            else
                bcd_adj[4*k +: 4] = bcd_reg[4*k +: 4];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        bits_next      = bits_reg;
        left_next      = left_reg;
        neg_next       = neg_reg;
        started_next   = started_reg;
        out_char_next  = out_char_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && out_stall;
        q_pop          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_cmd.op)
                        OP_CHAR:
                        begin
                            if (out_free)
                            begin
                                q_pop          = 1'b1;
                                out_valid_next = 1'b1;
                                out_char_next  = q_cmd.value[7:0];
                                last_next      = 1'b1;
                            end
                        end
                        OP_DEC:
                        begin
                            q_pop        = 1'b1;
                            neg_next     = q_cmd.neg;
                            started_next = 1'b0;
                            bcd_next     = '0;
                            left_next    = 4'(DEC_DIGITS);
                            bin_next     = q_cmd.wide ? q_cmd.value
                                                      : {q_cmd.value[15:0], 16'h0000};
                            bits_next    = q_cmd.wide ? 6'd32 : 6'd16;
                            state_next   = ST_CONV;
                        end
                        OP_HEX:
                        begin
                            q_pop        = 1'b1;
                            neg_next     = 1'b0;
                            started_next = 1'b1;
                            bcd_next     = {q_cmd.value[15:0], {(BCD_W - 16){1'b0}}};
                            left_next    = 4'(HEX_DIGITS);
                            state_next   = ST_EMIT;
                        end
                        default:
                            q_pop = 1'b1;
                    endcase
                end
            end
            ST_CONV:
            begin
                bcd_next  = {bcd_adj[BCD_W-2:0], bin_reg[31]};
                bin_next  = {bin_reg[30:0], 1'b0};
                bits_next = bits_reg - 6'd1;
                if (bits_reg == 6'd1)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    if (neg_reg)
                    begin
                        neg_next       = 1'b0;
                        out_valid_next = 1'b1;
                        out_char_next  = CHAR_MINUS;
                        last_next      = 1'b0;
                    end
                    else
                    begin
                        bcd_next  = {bcd_reg[BCD_W-5:0], 4'h0};
                        left_next = left_reg - 4'd1;
                        // leading zeros are dropped, but the final digit always goes
                        if (top_digit != 4'h0 || started_reg || left_reg == 4'd1)
                        begin
                            started_next   = 1'b1;
                            out_valid_next = 1'b1;
                            out_char_next  = digit_char(top_digit);
                            last_next      = (left_reg == 4'd1);
                        end
                        if (left_reg == 4'd1)
                            state_next = ST_IDLE;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg      <= bin_next;
        bcd_reg      <= bcd_next;
        bits_reg     <= bits_next;
        left_reg     <= left_next;
        neg_reg      <= neg_next;
        started_reg  <= started_next;
        out_char_reg <= out_char_next;
        last_reg     <= last_next;
    end

endmodule

`default_nettype wire

@@ verif/tb_printf_number_formatter_core.sv @@
// Self-checking testbench for printf_number_formatter_core: directed and random
// format streams, random input gaps and output stalls, checked by a predictor.
// Depends on pnf_pkg and the formatter RTL.
`timescale 1ns / 100ps

module tb_printf_number_formatter_core;

    import pnf_pkg::*;

    localparam int RANDOM_ITEMS = 175;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 60;
    localparam int LIMIT_CYCLES = 600000;

    localparam logic [7:0] CONV_SET [7] = '{CHAR_CONV_I, CHAR_CONV_U, CHAR_CONV_L,
                                            CHAR_CONV_N, CHAR_CONV_X, CHAR_CONV_C,
                                            CHAR_PERCENT};

    // Predicts the character stream and holds what is still owed by the block.
    class char_stream_board;
        typedef struct {
            logic [7:0] code;
            logic       last;
        } out_char_t;

        out_char_t expected_chars[$];
        bit        conv_open;
        int        items_seen;
        int        conversions;
        int        chars_checked;
        int        errors;
        string     hex_set = "0123456789ABCDEF";

        function int pending();
            return expected_chars.size();
        endfunction

        function void note_error(string what);
            errors++;
            if (errors <= 10)
                $display("mismatch: %s", what);
        endfunction

        function void note_format_item(logic [7:0] ch, logic [31:0] arg);
            logic [7:0]  line[$];
            logic [7:0]  digits[$];
            logic [31:0] mag;
            bit          wide;
            bit          neg;
            out_char_t   e;
            items_seen++;
            if (!conv_open)
            begin
                if (ch == CHAR_PERCENT)
                    conv_open = 1'b1;
                else if (ch != CHAR_NUL)
                    line.push_back(ch);
            end
            else
            begin
                conv_open = 1'b0;
                if (ch != CHAR_NUL)
                    conversions++;
                case (ch)
                    CHAR_NUL:
                    begin
                    end
                    CHAR_CONV_C:
                        line.push_back(arg[7:0]);
                    CHAR_CONV_X:
                        for (int k = 3; k >= 0; k--)
                            line.push_back(hex_set[arg[4*k +: 4]]);
                    CHAR_CONV_I, CHAR_CONV_U, CHAR_CONV_L, CHAR_CONV_N:
                    begin
                        wide = (ch == CHAR_CONV_L) || (ch == CHAR_CONV_N);
                        neg  = ((ch == CHAR_CONV_I) && arg[15]) ||
                               ((ch == CHAR_CONV_L) && arg[31]);
                        mag  = wide ? arg : {16'h0000, arg[15:0]};
                        if (neg)
                        begin
                            line.push_back(CHAR_MINUS);
                            // most negative value wraps to itself, read unsigned
                            mag = wide ? 32'h0 - arg : {16'h0000, 16'h0000 - arg[15:0]};
                        end
                        do
                        begin
                            digits.push_front(CHAR_ZERO + 8'(mag % 32'd10));
                            mag = mag / 32'd10;
                        end
                        while (mag != 0);
                        line = {line, digits};
                    end
                    default:
                        line.push_back(ch);
                endcase
            end
            foreach (line[i])
            begin
                e.code = line[i];
                e.last = (i == line.size() - 1);
                expected_chars.push_back(e);
            end
        endfunction

        function void check_out_char(logic [7:0] code, logic last);
            out_char_t e;
            chars_checked++;
            if (expected_chars.size() == 0)
                note_error($sformatf("unexpected char %h last %b", code, last));
            else
            begin
                e = expected_chars.pop_front();
                if (e.code !== code || e.last !== last)
                    note_error($sformatf("char exp %h got %h, last exp %b got %b",
                                         e.code, code, e.last, last));
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    wire logic   in_stall;
    logic [7:0]  format_char;
    logic [31:0] arg_word;
    wire logic   out_valid;
    logic        out_stall;
    wire logic [7:0] out_char;
    wire logic   last_char;

    bit fast_mode = 1'b0;
    bit hold_req  = 1'b0;
    int items_sent = 0;

    char_stream_board sb;

    printf_number_formatter_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .format_char (format_char),
        .arg_word    (arg_word),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_char    (out_char),
        .last_char   (last_char)
    );

    always #10 clk = ~clk;

    function automatic int pick_gap();
        int r;
        if (fast_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] pick_arg();
        case ($urandom_range(0, 4))
            0:       return $urandom;
            1:       return $urandom_range(0, 20);
            2:       return $urandom >> $urandom_range(0, 31);
            3:       return 32'h0 - $urandom_range(1, 1000);
            default: return {16'($urandom), 16'h0000 - 16'($urandom_range(1, 1000))};
        endcase
    endfunction

    task automatic send_item(input logic [7:0] ch, input logic [31:0] arg);
        int gap;
        @(negedge clk);
        in_valid    <= 1'b1;
        format_char <= ch;
        arg_word    <= arg;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_format_item(ch, arg);
        items_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_conv(input logic [7:0] conv, input logic [31:0] arg);
        send_item(CHAR_PERCENT, $urandom);
        send_item(conv, arg);
    endtask

    task automatic send_random_sequence();
        int         r;
        logic [7:0] conv;
        r = $urandom_range(0, 9);
        if (r < 7)
        begin
            // mostly well-formed conversions, now and then an odd character
            conv = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                               : CONV_SET[$urandom_range(0, 6)];
            send_conv(conv, pick_arg());
        end
        else if (r < 9)
            send_item(8'($urandom_range(1, 255)), $urandom);
        else
            send_item(8'($urandom), $urandom);
    endtask

    task automatic run_random(input int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
            send_random_sequence();
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // receiver stall pattern; a long hold-off is counted here on request
    initial
    begin
        int stall_left;
        int hold_left;
        out_stall  = 1'b0;
        stall_left = 0;
        hold_left  = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if ($urandom_range(0, 2) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_out_char(out_char, last_char);
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("timeout after %0d cycles, %0d characters outstanding",
                 LIMIT_CYCLES, sb.pending());
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        sb          = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        format_char = 8'h00;
        arg_word    = 32'h0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, every conversion, edge values
        send_item("A", 32'h0000_0000);
        send_item(CHAR_NUL, 32'hFFFF_FFFF);
        send_item(8'hFF, 32'h0000_0000);
        send_conv(CHAR_PERCENT, 32'h0000_0000);
        send_conv(CHAR_NUL, 32'hFFFF_FFFF);
        send_conv(CHAR_CONV_I, 32'h0000_8000);
        send_conv(CHAR_CONV_I, 32'h0000_7FFF);
        send_conv(CHAR_CONV_I, 32'hFFFF_0000);
        send_conv(CHAR_CONV_U, 32'h0000_FFFF);
        send_conv(CHAR_CONV_L, 32'h8000_0000);
        send_conv(CHAR_CONV_N, 32'hFFFF_FFFF);
        send_conv(CHAR_CONV_X, 32'hFFFF_BEEF);
        send_conv(CHAR_CONV_C, 32'h1234_5600);
        send_conv("s", 32'h0000_0001);
        wait_drained();

        // back-pressure: receiver holds off while the sender keeps offering
        hold_req  = 1'b1;
        fast_mode = 1'b1;
        repeat (10) send_conv(CONV_SET[$urandom_range(0, 4)], pick_arg());
        fast_mode = 1'b0;

        run_random(RANDOM_ITEMS * 2 / 5);
        fast_mode = 1'b1;
        run_random(RANDOM_ITEMS / 5);
        fast_mode = 1'b0;
        wait_drained();
        run_random(RANDOM_ITEMS * 2 / 5);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.note_error($sformatf("%0d characters never arrived", sb.pending()));

        $display("summary: %0d format items, %0d conversions, %0d output characters checked",
                 sb.items_seen, sb.conversions, sb.chars_checked);
        if (sb.errors == 0)
            $display("tb: success");
        else
        begin
            $display("%0d errors in total", sb.errors);
            $display("tb: failure");
        end
        $finish;
    end

endmodule
